// ----- sv/pfm_pkg.sv -----
// shared types, widths and constants of the perspective forward map
package pfm_pkg;
	localparam int CoordW = 12;
	localparam int PixW = 24;
	localparam int CoefW = 32;
	localparam int ProdW = CoefW + CoordW + 1;
	localparam int SumW = ProdW + 2;
	localparam int NumW = SumW + 16;
	localparam int DenW = SumW + 1;
	localparam int QuoW = CoordW + 1;
	localparam int DivStages = QuoW + 1;
	localparam int FrontStages = 3;
	localparam int Latency = FrontStages + DivStages;
	localparam int DefOutRows = 1024;
	localparam int DefOutCols = 1024;

	localparam logic [2:0] RegH00 = 3'd0;
	localparam logic [2:0] RegH01 = 3'd1;
	localparam logic [2:0] RegH02 = 3'd2;
	localparam logic [2:0] RegH10 = 3'd3;
	localparam logic [2:0] RegH11 = 3'd4;
	localparam logic [2:0] RegH12 = 3'd5;
	localparam logic [2:0] RegH20 = 3'd6;
	localparam logic [2:0] RegH21 = 3'd7;

	typedef struct packed {
		logic signed [CoefW-1:0] h00;
		logic signed [CoefW-1:0] h01;
		logic signed [CoefW-1:0] h02;
		logic signed [CoefW-1:0] h10;
		logic signed [CoefW-1:0] h11;
		logic signed [CoefW-1:0] h12;
		logic signed [CoefW-1:0] h20;
		logic signed [CoefW-1:0] h21;
	} coef_t;

	typedef struct packed {
		logic [NumW-1:0] num_r;
		logic [NumW-1:0] num_c;
		logic [DenW-1:0] den;
		logic            neg_r;
		logic            neg_c;
		logic            w_zero;
	} frac_t;

	typedef struct packed {
		logic            valid;
		logic [PixW-1:0] pixel;
	} side_t;
endpackage

// ----- sv/perspective_forward_map.sv -----
// top level: coefficient registers, pipeline control and output register
// Maps each source pixel (src_row, src_col, pixel_in) through a homography
// with h22 fixed at 1 and rounds x/w and y/w half away from zero.
// Input channel: src_valid / src_stall; a transaction moves at a clock edge
// with src_valid high and src_stall low. Result channel: res_valid / res_stall
// the same way, carrying dest_valid, dest_row, dest_col and pixel_out.
// Coefficients h00..h21 are written through cfg_we / cfg_index / cfg_data,
// index order h00 h01 h02 h10 h11 h12 h20 h21. The user must write them only
// while the block is idle; the block does not enforce this. A transaction
// passes three stages of products and sums, one range-check stage and
// thirteen quotient-bit stages of the divider, then the output register.
// Throughput is one transaction per cycle, set by the fully pipelined
// divider, while no result waits under res_stall. dest_valid is low for zero
// w or a coordinate outside the output frame, and then dest_row and dest_col
// read 0. Reset empties the pipeline and loads the identity mapping.
// While a result waits under res_stall the whole pipeline holds and
// src_stall is raised; nothing is lost or repeated.
module perspective_forward_map #(
	parameter int OUT_ROWS = pfm_pkg::DefOutRows,
	parameter int OUT_COLS = pfm_pkg::DefOutCols
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [pfm_pkg::CoefW-1:0]    cfg_data,
	input  logic                         src_valid,
	output logic                         src_stall,
	input  logic [pfm_pkg::CoordW-1:0]   src_row,
	input  logic [pfm_pkg::CoordW-1:0]   src_col,
	input  logic [pfm_pkg::PixW-1:0]     pixel_in,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         dest_valid,
	output logic [pfm_pkg::CoordW-1:0]   dest_row,
	output logic [pfm_pkg::CoordW-1:0]   dest_col,
	output logic [pfm_pkg::PixW-1:0]     pixel_out
);
	import pfm_pkg::*;

	localparam logic [QuoW-1:0] RowLim = QuoW'(OUT_ROWS);
	localparam logic [QuoW-1:0] ColLim = QuoW'(OUT_COLS);

	coef_t           coef_q;
	frac_t           frac;
	side_t           side_s [Latency];
	logic            wz_s [DivStages];
	logic            en;
	logic            out_valid_q;
	logic [QuoW-1:0] q_r, q_c;
	logic            ovf_r, ovf_c, neg_r, neg_c;
	logic            ok_r, ok_c, ok;

	assign en = !(out_valid_q && res_stall);
	assign src_stall = out_valid_q && res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '{h00: 32'sd65536, h11: 32'sd65536, default: '0};
		end else if (cfg_we) begin
			case (cfg_index)
				RegH00: coef_q.h00 <= cfg_data;
				RegH01: coef_q.h01 <= cfg_data;
				RegH02: coef_q.h02 <= cfg_data;
				RegH10: coef_q.h10 <= cfg_data;
				RegH11: coef_q.h11 <= cfg_data;
				RegH12: coef_q.h12 <= cfg_data;
				RegH20: coef_q.h20 <= cfg_data;
				RegH21: coef_q.h21 <= cfg_data;
				default: ;
			endcase
		end
	end

	pfm_front u_front (
		.clk  (clk),
		.en   (en),
		.coef (coef_q),
		.row  (src_row),
		.col  (src_col),
		.frac (frac)
	);

	pfm_div u_div_r (
		.clk     (clk),
		.en      (en),
		.num     (frac.num_r),
		.den     (frac.den),
		.neg     (frac.neg_r),
		.quo     (q_r),
		.ovf     (ovf_r),
		.neg_out (neg_r)
	);

	pfm_div u_div_c (
		.clk     (clk),
		.en      (en),
		.num     (frac.num_c),
		.den     (frac.den),
		.neg     (frac.neg_c),
		.quo     (q_c),
		.ovf     (ovf_c),
		.neg_out (neg_c)
	);

	// valid bits and pixel travel alongside the arithmetic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Latency; i++) side_s[i] <= '0;
		end else if (en) begin
			side_s[0] <= '{valid: src_valid, pixel: pixel_in};
			for (int i = 1; i < Latency; i++) side_s[i] <= side_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_s[0] <= frac.w_zero;
			for (int i = 1; i < DivStages; i++) wz_s[i] <= wz_s[i-1];
		end
	end

	assign ok_r = !ovf_r && ((q_r == '0) || (!neg_r && q_r < RowLim));
	assign ok_c = !ovf_c && ((q_c == '0) || (!neg_c && q_c < ColLim));
	assign ok = ok_r && ok_c && !wz_s[DivStages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side_s[Latency-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dest_valid <= ok;
			dest_row <= ok ? q_r[CoordW-1:0] : '0;
			dest_col <= ok ? q_c[CoordW-1:0] : '0;
			pixel_out <= side_s[Latency-1].pixel;
		end
	end

	assign res_valid = out_valid_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !dest_valid |-> dest_row == '0 && dest_col == '0)
		else $error("invalid result with nonzero coordinates");
	a_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !src_stall)
		else $error("input stalled with empty output register");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(pixel_out) && $stable(dest_row))
		else $error("stalled result changed");
endmodule

// ----- sv/pfm_front.sv -----
// products, sums and magnitudes of the homography, three stages
module pfm_front (
	input  logic                        clk,
	input  logic                        en,
	input  pfm_pkg::coef_t              coef,
	input  logic [pfm_pkg::CoordW-1:0]  row,
	input  logic [pfm_pkg::CoordW-1:0]  col,
	output pfm_pkg::frac_t              frac
);
	import pfm_pkg::*;

	logic signed [ProdW-1:0] p_s1 [6];
	logic signed [SumW-1:0]  x_s2, y_s2, w_s2;
	logic signed [CoordW:0]  r_se, c_se;
	logic [SumW-1:0]         mx, my, mw;

	assign r_se = $signed({1'b0, row});
	assign c_se = $signed({1'b0, col});

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= ProdW'(coef.h00 * r_se);
			p_s1[1] <= ProdW'(coef.h01 * c_se);
			p_s1[2] <= ProdW'(coef.h10 * r_se);
			p_s1[3] <= ProdW'(coef.h11 * c_se);
			p_s1[4] <= ProdW'(coef.h20 * r_se);
			p_s1[5] <= ProdW'(coef.h21 * c_se);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= SumW'(p_s1[0]) + SumW'(p_s1[1]) + SumW'(coef.h02);
			y_s2 <= SumW'(p_s1[2]) + SumW'(p_s1[3]) + SumW'(coef.h12);
			w_s2 <= SumW'(p_s1[4]) + SumW'(p_s1[5]) + (SumW'(1) <<< 30);
		end
	end

	assign mx = x_s2[SumW-1] ? SumW'(-x_s2) : SumW'(x_s2);
	assign my = y_s2[SumW-1] ? SumW'(-y_s2) : SumW'(y_s2);
	assign mw = w_s2[SumW-1] ? SumW'(-w_s2) : SumW'(w_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			frac.num_r  <= (NumW'(mx) << 15) + NumW'(mw);
			frac.num_c  <= (NumW'(my) << 15) + NumW'(mw);
			frac.den    <= {mw, 1'b0};
			frac.neg_r  <= x_s2[SumW-1] != w_s2[SumW-1];
			frac.neg_c  <= y_s2[SumW-1] != w_s2[SumW-1];
			frac.w_zero <= w_s2 == '0;
		end
	end
endmodule

// ----- sv/pfm_div.sv -----
// pipelined restoring divider, one quotient bit per stage with range check
module pfm_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [pfm_pkg::NumW-1:0]   num,
	input  logic [pfm_pkg::DenW-1:0]   den,
	input  logic                       neg,
	output logic [pfm_pkg::QuoW-1:0]   quo,
	output logic                       ovf,
	output logic                       neg_out
);
	import pfm_pkg::*;

	logic [NumW-1:0] rem_s [QuoW+1];
	logic [DenW-1:0] den_s [QuoW+1];
	logic [QuoW-1:0] quo_s [QuoW+1];
	logic            neg_s [QuoW+1];
	logic            ovf_s [QuoW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= num >= (NumW'(den) << QuoW);
		end
	end

	for (genvar i = 1; i <= QuoW; i++) begin : g_step
		localparam int K = QuoW - i;
		logic [NumW-1:0] sh;
		logic            ge;
		assign sh = NumW'(den_s[i-1]) << K;
		assign ge = rem_s[i-1] >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? rem_s[i-1] - sh : rem_s[i-1];
				den_s[i] <= den_s[i-1];
				quo_s[i] <= quo_s[i-1] | (QuoW'(ge) << K);
				neg_s[i] <= neg_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	assign quo = quo_s[QuoW];
	assign ovf = ovf_s[QuoW];
	assign neg_out = neg_s[QuoW];
endmodule

// ----- dv/perspective_forward_map_tb.sv -----
// self-checking testbench for the perspective forward map: directed and random pixels
`timescale 1ns / 100ps

module perspective_forward_map_tb;
	import pfm_pkg::*;

	localparam int OutRows = DefOutRows;
	localparam int OutCols = DefOutCols;
	localparam int StallLimit = 4000;

	typedef struct packed {
		logic            ok;
		logic [CoordW-1:0] row;
		logic [CoordW-1:0] col;
		logic [PixW-1:0]   pix;
	} mapped_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [CoefW-1:0] cfg_data;
	logic src_valid;
	logic src_stall;
	logic [CoordW-1:0] src_row;
	logic [CoordW-1:0] src_col;
	logic [PixW-1:0] pixel_in;
	logic res_valid;
	logic res_stall;
	logic dest_valid;
	logic [CoordW-1:0] dest_row;
	logic [CoordW-1:0] dest_col;
	logic [PixW-1:0] pixel_out;

	longint coef [8];
	mapped_t mapped_q [$];
	int errors;
	bit src_idle_en;
	bit res_idle_en;
	bit hold_off;
	int quiet_cycles;

	perspective_forward_map u_top (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit round_coord(longint num, longint den, longint lim,
		output logic [CoordW-1:0] q_out);
		longint un;
		longint ud;
		longint q;
		bit neg;
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		q = (2 * un + ud) / (2 * ud);
		neg = (num < 0) != (den < 0);
		q_out = '0;
		if (q == 0)
			return 1'b1;
		if (neg || q >= lim)
			return 1'b0;
		q_out = q[CoordW-1:0];
		return 1'b1;
	endfunction

	function automatic mapped_t map_pixel(logic [CoordW-1:0] r_in, logic [CoordW-1:0] c_in,
		logic [PixW-1:0] pix);
		mapped_t m;
		longint r;
		longint c;
		longint x;
		longint y;
		longint w;
		bit okr;
		bit okc;
		r = r_in;
		c = c_in;
		x = coef[0] * r + coef[1] * c + coef[2];
		y = coef[3] * r + coef[4] * c + coef[5];
		w = coef[6] * r + coef[7] * c + (64'sd1 <<< 30);
		m.ok = 1'b0;
		m.row = '0;
		m.col = '0;
		m.pix = pix;
		if (w != 0) begin
			okr = round_coord(x * 16384, w, OutRows, m.row);
			okc = round_coord(y * 16384, w, OutCols, m.col);
			m.ok = okr && okc;
		end
		if (!m.ok) begin
			m.row = '0;
			m.col = '0;
		end
		return m;
	endfunction

	task automatic write_coef(logic [2:0] idx, logic [CoefW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		coef[idx] = longint'(signed'(val));
		@(posedge clk);
	endtask

	task automatic load_homography(logic [CoefW-1:0] a0, logic [CoefW-1:0] a1,
		logic [CoefW-1:0] a2, logic [CoefW-1:0] b0, logic [CoefW-1:0] b1,
		logic [CoefW-1:0] b2, logic [CoefW-1:0] p0, logic [CoefW-1:0] p1);
		write_coef(RegH00, a0);
		write_coef(RegH01, a1);
		write_coef(RegH02, a2);
		write_coef(RegH10, b0);
		write_coef(RegH11, b1);
		write_coef(RegH12, b2);
		write_coef(RegH20, p0);
		write_coef(RegH21, p1);
	endtask

	task automatic drain;
		int n;
		n = 0;
		src_valid <= 1'b0;
		while (mapped_q.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (Latency + 4) @(posedge clk);
	endtask

	task automatic send_pixel(logic [CoordW-1:0] r, logic [CoordW-1:0] c,
		logic [PixW-1:0] pix);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_row <= r;
		src_col <= c;
		pixel_in <= pix;
		do @(posedge clk); while (src_stall);
		mapped_q.push_back(map_pixel(r, c, pix));
	endtask

	function automatic logic [CoefW-1:0] rand_coef(int kind);
		case (kind)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			default: return $urandom_range(0, 131072) - 65536;
		endcase
	endfunction

	task automatic test_identity;
		send_pixel(0, 0, 24'h000000);
		send_pixel(4095, 4095, 24'hffffff);
		send_pixel(1023, 1023, 24'ha5a5a5);
		send_pixel(1024, 5, 24'h5a5a5a);
		send_pixel(5, 1024, 24'h123456);
		send_pixel(0, 4095, 24'h800001);
		drain();
	endtask

	task automatic test_special_cases;
		// w zero at row 1
		load_homography(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 32'hc000_0000, 0);
		send_pixel(1, 3, 24'h0f0f0f);
		send_pixel(0, 3, 24'hf0f0f0);
		send_pixel(2, 7, 24'h00ff00);
		drain();
		// small negative quotient rounds to zero, larger negative is out
		load_homography(0, 0, 32'hffff_999a, 0, 0, 32'hffff_0000, 0, 0);
		send_pixel(3, 3, 24'h111111);
		drain();
		// half way rounding away from zero, and frame edges
		load_homography(32'h0000_8000, 0, 0, 0, 32'h0000_8000, 32'h0000_8000, 0, 0);
		send_pixel(1, 1, 24'h222222);
		send_pixel(2047, 2046, 24'h333333);
		send_pixel(2048, 2045, 24'h444444);
		send_pixel(3, 2047, 24'h555555);
		drain();
		load_homography(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_pixel(4095, 0, 24'h666666);
		send_pixel(0, 4095, 24'h777777);
		send_pixel(4095, 4095, 24'h888888);
		drain();
		// unknown index does not exist in a 3 bit field; every index is covered
		write_coef(RegH21, 0);
	endtask

	task automatic test_random_maps(int sets, int per_set);
		int kind;
		for (int s = 0; s < sets; s++) begin
			kind = $urandom_range(0, 3);
			if (kind == 0)
				load_homography(rand_coef(3), rand_coef(3), rand_coef(3) <<< 8,
					rand_coef(3), rand_coef(3), rand_coef(3) <<< 8,
					$urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048);
			else if (kind == 1)
				load_homography(rand_coef($urandom_range(0, 3)), rand_coef($urandom_range(0, 3)),
					rand_coef($urandom_range(0, 3)), rand_coef($urandom_range(0, 3)),
					rand_coef($urandom_range(0, 3)), rand_coef($urandom_range(0, 3)),
					rand_coef($urandom_range(0, 3)), rand_coef($urandom_range(0, 3)));
			else
				load_homography(32'h0000_4000 + $urandom_range(0, 32768), $urandom_range(0, 8192),
					$urandom_range(0, 1 << 24), $urandom_range(0, 8192),
					32'h0000_4000 + $urandom_range(0, 32768), $urandom_range(0, 1 << 24),
					$urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000);
			for (int i = 0; i < per_set; i++)
				send_pixel(CoordW'($urandom_range(0, 4095) >> $urandom_range(0, 2)),
					CoordW'($urandom_range(0, 4095) >> $urandom_range(0, 2)),
					PixW'($urandom()));
			drain();
		end
	endtask

	task automatic test_backpressure;
		load_homography(32'h0001_0000, 0, 32'h0010_0000, 0, 32'h0001_0000, 0, 0, 0);
		hold_off = 1'b1;
		for (int i = 0; i < 60; i++)
			send_pixel(CoordW'($urandom_range(0, 4095)), CoordW'($urandom_range(0, 4095)),
				PixW'($urandom()));
		drain();
	endtask

	// receiver stalls: random bursts, and one long hold off on request
	always @(posedge clk) begin
		if (hold_off) begin
			res_stall <= 1'b1;
			hold_off = 1'b0;
			repeat (80) @(posedge clk);
			res_stall <= 1'b0;
		end else if (res_idle_en && $urandom_range(0, 5) == 0) begin
			res_stall <= 1'b1;
			repeat ($urandom_range(1, 3)) @(posedge clk);
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		mapped_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (mapped_q.size() == 0) begin
				$display("%0t: unexpected result, got %b %0d %0d %h", $time, dest_valid,
					dest_row, dest_col, pixel_out);
				errors++;
			end else begin
				want = mapped_q.pop_front();
				if (dest_valid !== want.ok || dest_row !== want.row ||
					dest_col !== want.col || pixel_out !== want.pix) begin
					$display("%0t: mismatch, expected %b %0d %0d %h, got %b %0d %0d %h", $time,
						want.ok, want.row, want.col, want.pix, dest_valid, dest_row,
						dest_col, pixel_out);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (res_valid && !res_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		quiet_cycles = 0;
		hold_off = 1'b0;
		src_idle_en = 1'b1;
		res_idle_en = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_valid = 1'b0;
		src_row = '0;
		src_col = '0;
		pixel_in = '0;
		res_stall = 1'b0;
		coef = '{65536, 0, 0, 0, 65536, 0, 0, 0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity();
		test_special_cases();
		test_backpressure();
		test_random_maps(24, 40);
		src_idle_en = 1'b0;
		res_idle_en = 1'b0;
		test_random_maps(3, 40);
		drain();
		if (errors == 0 && mapped_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
